FILE: src/kld_pkg.sv
// ----------------------------------------------------------------------------
// kld_pkg: shared types and constants for the k-th largest distinct select unit
// Transaction payloads, controller commands and datapath status.
// ----------------------------------------------------------------------------
package kld_pkg;

   localparam int DATA_W = 32;
   localparam int RANK_W = 7;

   localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);
   localparam logic signed [DATA_W-1:0] NOT_FOUND_VALUE = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_value;
      logic                     last_item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] selected_value;
      logic                     found;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new transaction, restart the duplicate scan
      logic rd_dedup;    // read the next entry for the duplicate check
      logic rd_sel;      // read the next entry for a selection pass
      logic store;       // append the sample if it is new and there is room
      logic sel_init;    // start the first selection pass
      logic next_pass;   // lower the threshold to the best value of this pass
      logic resp_found;  // drive the best value as the result
      logic resp_miss;   // drive the not-found result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_done;    // every stored entry has been read
      logic last;        // the held transaction closes the data set
      logic rank_ok;     // 1 <= rank <= distinct count
      logic pass_hit;    // the current pass number equals the rank
   } status_type;

endpackage

FILE: src/kth_largest_distinct_select_unit.sv
// ----------------------------------------------------------------------------
// kth_largest_distinct_select_unit: k-th largest distinct value selector
// Collects a data set one transaction at a time, keeps the first copy of
// each value, and after the final item returns the k-th largest distinct one or not-found.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Handshake
//   -------   ---------------------------------   ---------------------------
//   request   start, busy, req_payload            taken when start && !busy
//   response  rsp_strobe, rsp_payload             one-cycle strobe, no stall
//   config    csr_wr_en, csr_wr_data              written when csr_wr_en
//
// Each transaction first scans the n distinct values already stored through
// the single read port of the store and then stores or drops its sample,
// holding busy throughout. A final item then runs one selection pass per
// rank step, each a full scan of the n stored values, before the strobe.
// Both costs come from the store's single read port. The receiver cannot stall;
// the strobe lasts exactly one cycle. Reset clears the count and the control
// state and sets the rank to 1; no clearing pass is needed.
//
module kth_largest_distinct_select_unit #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel: one data set element per transaction.
   input  logic                        start,
   output logic                        busy,
   input  kld_pkg::req_type            req_payload,
   // Response channel: one result at the end of each data set.
   output logic                        rsp_strobe,
   output kld_pkg::rsp_type            rsp_payload,
   // Rank register.
   input  logic                        csr_wr_en,
   input  logic [kld_pkg::RANK_W-1:0]  csr_wr_data
);

   // Commands flow one way and status the other; nothing else joins the two.
   kld_pkg::cmd_type    cmd;
   kld_pkg::status_type status;

   // The controller decides the order of scans, stores and selection passes.
   kld_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the store, the scan counter and the comparators. A
   // selection pass finds the largest value below the previous pass's winner,
   // so the k-th pass yields the k-th largest distinct value.
   kld_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/kld_datapath.sv
// ----------------------------------------------------------------------------
// kld_datapath: store, scan counter and comparators
// Holds the distinct value memory, performs duplicate checks and the
// threshold-based selection passes, and registers the result.
// ----------------------------------------------------------------------------
module kld_datapath #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kld_pkg::req_type            req_payload,
   input  logic                        csr_wr_en,
   input  logic [kld_pkg::RANK_W-1:0]  csr_wr_data,
   input  kld_pkg::cmd_type            cmd,
   output kld_pkg::status_type         status,
   output kld_pkg::rsp_type            rsp_payload
);

   localparam int CW   = $clog2(MAX_ITEMS + 1);
   localparam int AW   = $clog2(MAX_ITEMS);
   localparam int CMPW = (CW > kld_pkg::RANK_W) ? CW : kld_pkg::RANK_W;

   logic signed [kld_pkg::DATA_W-1:0] store_mem [MAX_ITEMS];

   logic [kld_pkg::RANK_W-1:0]        rank_ff;
   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     idx_ff;
   logic [kld_pkg::RANK_W-1:0]        pass_ff;
   logic                              dup_ff;
   logic                              rd_vld_ff;
   logic                              rd_sel_ff;
   logic                              thresh_vld_ff;
   logic                              best_vld_ff;
   logic signed [kld_pkg::DATA_W-1:0] sample_ff;
   logic                              last_ff;
   logic signed [kld_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [kld_pkg::DATA_W-1:0] thresh_ff;
   logic signed [kld_pkg::DATA_W-1:0] best_ff;
   kld_pkg::rsp_type                  rsp_ff;

   logic                              room;
   logic                              do_write;
   logic                              eligible;
   logic                              take_best;
   logic [CMPW-1:0]                   rank_ext;
   logic [CMPW-1:0]                   count_ext;

   assign room      = (count_ff < CW'(MAX_ITEMS));
   assign do_write  = cmd.store && !dup_ff && room;
   assign eligible  = !thresh_vld_ff || (rd_data_ff < thresh_ff);
   assign take_best = rd_vld_ff && rd_sel_ff && eligible &&
                      (!best_vld_ff || (rd_data_ff > best_ff));
   assign rank_ext  = CMPW'(rank_ff);
   assign count_ext = CMPW'(count_ff);

   assign status.idx_done = (idx_ff == count_ff);
   assign status.last     = last_ff;
   assign status.rank_ok  = (rank_ff != '0) && (rank_ext <= count_ext);
   assign status.pass_hit = (pass_ff == rank_ff);
   assign rsp_payload     = rsp_ff;

   // Memory with one write port and a single registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[count_ff[AW-1:0]] <= sample_ff;
      end
      if (cmd.rd_dedup || cmd.rd_sel) begin
         rd_data_ff <= store_mem[idx_ff[AW-1:0]];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_payload.sample_value;
         last_ff   <= req_payload.last_item;
      end
      if (cmd.next_pass) begin
         thresh_ff <= best_ff;
      end
      if (take_best) begin
         best_ff <= rd_data_ff;
      end
      if (cmd.resp_found) begin
         rsp_ff.selected_value <= best_ff;
         rsp_ff.found          <= 1'b1;
      end else if (cmd.resp_miss) begin
         rsp_ff.selected_value <= kld_pkg::NOT_FOUND_VALUE;
         rsp_ff.found          <= 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff       <= kld_pkg::RANK_RESET;
         count_ff      <= '0;
         idx_ff        <= '0;
         pass_ff       <= '0;
         dup_ff        <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_sel_ff     <= 1'b0;
         thresh_vld_ff <= 1'b0;
         best_vld_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rank_ff <= csr_wr_data;
         end
         rd_vld_ff <= cmd.rd_dedup || cmd.rd_sel;
         rd_sel_ff <= cmd.rd_sel;
         if (cmd.rd_dedup || cmd.rd_sel) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.load) begin
            idx_ff <= '0;
            dup_ff <= 1'b0;
         end else if (rd_vld_ff && !rd_sel_ff && (rd_data_ff == sample_ff)) begin
            dup_ff <= 1'b1;
         end
         if (do_write) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.sel_init) begin
            idx_ff        <= '0;
            pass_ff       <= kld_pkg::RANK_W'(1);
            thresh_vld_ff <= 1'b0;
            best_vld_ff   <= 1'b0;
         end else if (cmd.next_pass) begin
            idx_ff        <= '0;
            pass_ff       <= pass_ff + kld_pkg::RANK_W'(1);
            thresh_vld_ff <= 1'b1;
            best_vld_ff   <= 1'b0;
         end else if (take_best) begin
            best_vld_ff <= 1'b1;
         end
         if (cmd.resp_found || cmd.resp_miss) begin
            count_ff <= '0;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("distinct count exceeds store depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_dedup || cmd.rd_sel) |-> (idx_ff < count_ff))
      else $error("store read beyond the filled entries");

   a_found_has_best: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_found |-> best_vld_ff)
      else $error("result taken from a pass that found no candidate");

endmodule

FILE: src/kld_controller.sv
// ----------------------------------------------------------------------------
// kld_controller: sequencing state machine
// Steps each transaction through the duplicate scan, the store and, on the
// final item, the selection passes, and raises the result strobe.
// ----------------------------------------------------------------------------
module kld_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   input  kld_pkg::status_type status,
   output kld_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEDUP,
      ST_DEDUP_WAIT,
      ST_STORE,
      ST_SEL_CHECK,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_PASS_END
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DEDUP;
            end
         end
         ST_DEDUP: begin
            if (!status.idx_done) begin
               cmd.rd_dedup = 1'b1;
            end else begin
               state_in = ST_DEDUP_WAIT;
            end
         end
         ST_DEDUP_WAIT: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.last ? ST_SEL_CHECK : ST_IDLE;
         end
         ST_SEL_CHECK: begin
            if (status.rank_ok) begin
               cmd.sel_init = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               cmd.resp_miss = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!status.idx_done) begin
               cmd.rd_sel = 1'b1;
            end else begin
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            state_in = ST_PASS_END;
         end
         ST_PASS_END: begin
            if (status.pass_hit) begin
               cmd.resp_found = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.next_pass = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result shown while a transaction is still in work");

endmodule
